@@ hdl/shi_pkg.sv @@
// ----------------------------------------------------------------------------
// shi_pkg
// Shared types, codes and defaults for the selection handshake interlock.
// ----------------------------------------------------------------------------
package shi_pkg;

    localparam int SEL_ID_BITS_DEF = 32;
    localparam logic [31:0] FRESH_LIMIT_RST = 32'd750;

    // event opcodes
    localparam logic [3:0] OP_PRESTART  = 4'd0;
    localparam logic [3:0] OP_CHOOSE    = 4'd1;
    localparam logic [3:0] OP_CONFIRM   = 4'd2;
    localparam logic [3:0] OP_ACK       = 4'd3;
    localparam logic [3:0] OP_CAR_START = 4'd4;
    localparam logic [3:0] OP_STATUS    = 4'd5;
    localparam logic [3:0] OP_AP_LINK   = 4'd6;
    localparam logic [3:0] OP_VIS_LINK  = 4'd7;
    localparam logic [3:0] OP_AUTH_LOST = 4'd8;
    localparam logic [3:0] OP_TICK      = 4'd9;

    // reason codes
    localparam logic [7:0] RSN_NONE      = 8'd0;
    localparam logic [7:0] RSN_WAIT_EPO  = 8'd1;
    localparam logic [7:0] RSN_REJECTED  = 8'd2;
    localparam logic [7:0] RSN_EPO_MISM  = 8'd3;
    localparam logic [7:0] RSN_NO_SEL    = 8'd4;
    localparam logic [7:0] RSN_AUTH_RUN  = 8'd5;

    // link indices
    localparam logic [1:0] LK_AP     = 2'd0;
    localparam logic [1:0] LK_CAR    = 2'd1;
    localparam logic [1:0] LK_ROS    = 2'd2;
    localparam logic [1:0] LK_VISION = 2'd3;
    localparam int         NUM_LINKS = 4;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [31:0] now_ms;
        logic [63:0] boot_epoch;
        logic [3:0]  task_code;
        logic [31:0] ack_selection;
        logic        ack_accepted;
        logic [2:0]  ack_state;
        logic [7:0]  ack_reason;
        logic [7:0]  stage_in;
        logic        link_up;
        logic [1:0]  age_link;
    } t_in_word;

    typedef struct packed {
        logic        op_ok;
        logic [2:0]  ilk_state;
        logic        ctl_lock;
        logic [3:0]  task_sel;
        logic [31:0] selection_number;
        logic [7:0]  reason_code;
        logic        started;
        logic [7:0]  stage_rpt;
        logic [3:0]  fresh_flags;
        logic [31:0] link_age_ms;
    } t_out_word;

    // link record update requested by the state machine
    typedef struct packed {
        logic       touch;
        logic [1:0] idx;
        logic       up;
    } t_link_cmd;

    // what the link records report back for the word in flight
    typedef struct packed {
        logic        ros_ok;
        logic [3:0]  fresh_flags;
        logic [31:0] link_age;
    } t_link_stat;

    // next-state view of the interlock, captured into the result word
    typedef struct packed {
        logic        op_ok;
        logic [2:0]  ilk_state;
        logic        ctl_lock;
        logic [3:0]  task_sel;
        logic [31:0] selection_number;
        logic [7:0]  reason_code;
        logic        started;
        logic [7:0]  stage_rpt;
    } t_fsm_res;

endpackage

@@ hdl/shi_stream_if.sv @@
// ----------------------------------------------------------------------------
// shi_stream_if
// Valid/ready stream carrying one word of a given type.
// ----------------------------------------------------------------------------
interface shi_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/shi_links.sv @@
// ----------------------------------------------------------------------------
// shi_links
// Four link records (ap, car, ros, vision): last update, age and freshness.
// ----------------------------------------------------------------------------
module shi_links (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [3:0]             i_opcode,
    input  logic [31:0]            i_now_ms,
    input  logic [1:0]             i_age_link,
    input  logic [31:0]            i_fresh_limit,
    input  shi_pkg::t_link_cmd     i_cmd,
    output shi_pkg::t_link_stat    o_stat
);

    localparam int NL = shi_pkg::NUM_LINKS;

    logic [NL-1:0] r_conn;
    logic [NL-1:0] r_fresh;
    logic [31:0]   r_last [NL];
    logic [31:0]   r_age  [NL];

    logic [31:0]   age_new   [NL];
    logic [NL-1:0] fresh_new;
    logic          is_tick;

    assign is_tick = (i_opcode == shi_pkg::OP_TICK);

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            age_new[k]   = r_conn[k] ? (i_now_ms - r_last[k]) : i_now_ms;
            fresh_new[k] = r_conn[k] && (age_new[k] <= i_fresh_limit);
        end
    end

    always_comb begin
        o_stat.ros_ok      = fresh_new[shi_pkg::LK_ROS];
        o_stat.fresh_flags = is_tick ? fresh_new : r_fresh;
        o_stat.link_age    = is_tick ? age_new[i_age_link] : r_age[i_age_link];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn  <= '0;
            r_fresh <= '0;
            for (int k = 0; k < NL; k++) begin
                r_last[k] <= '0;
                r_age[k]  <= '0;
            end
        end else if (i_adv) begin
            if (is_tick) begin
                r_fresh <= fresh_new;
                for (int k = 0; k < NL; k++) begin
                    r_age[k] <= age_new[k];
                end
            end
            if (i_cmd.touch) begin
                r_conn[i_cmd.idx] <= i_cmd.up;
                r_last[i_cmd.idx] <= i_now_ms;
            end
        end
    end

endmodule

@@ hdl/shi_fsm.sv @@
// ----------------------------------------------------------------------------
// shi_fsm
// Interlock state machine: epoch and selection checks, faults, authority.
// ----------------------------------------------------------------------------
module shi_fsm #(
    parameter int SEL_BITS = shi_pkg::SEL_ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  shi_pkg::t_in_word    i_word,
    input  logic                 i_ros_ok,
    output shi_pkg::t_link_cmd   o_cmd,
    output shi_pkg::t_fsm_res    o_res
);

    localparam int CMP_W = (SEL_BITS > 32) ? SEL_BITS : 32;

    typedef enum logic [2:0] {
        ST_LOCKED   = 3'd0,
        ST_PRESTART = 3'd1,
        ST_PENDING  = 3'd2,
        ST_SELECTED = 3'd3,
        ST_ARMED    = 3'd4,
        ST_RUNNING  = 3'd5,
        ST_FAULT    = 3'd6
    } t_state;

    t_state              r_state,   n_state;
    logic                r_locked,  n_locked;
    logic [3:0]          r_task,    n_task;
    logic [SEL_BITS-1:0] r_sel,     n_sel;
    logic [63:0]         r_epoch,   n_epoch;
    logic [7:0]          r_reason,  n_reason;
    logic                r_started, n_started;
    logic [7:0]          r_stage,   n_stage;

    logic                ok;
    logic                may_sel;
    logic [SEL_BITS-1:0] sel_inc;
    logic [CMP_W-1:0]    sel_ext;
    logic                ack_hit;

    assign may_sel = (r_state == ST_PRESTART) && !r_locked;
    assign sel_inc = r_sel + SEL_BITS'(1);
    assign sel_ext = CMP_W'(r_sel);
    assign ack_hit = (r_state == ST_PENDING)
                   && (CMP_W'(i_word.ack_selection) == sel_ext)
                   && (i_word.boot_epoch == r_epoch);

    always_comb begin
        n_state   = r_state;
        n_locked  = r_locked;
        n_task    = r_task;
        n_sel     = r_sel;
        n_epoch   = r_epoch;
        n_reason  = r_reason;
        n_started = r_started;
        n_stage   = r_stage;
        ok        = 1'b0;
        o_cmd     = '{touch: 1'b0, idx: shi_pkg::LK_ROS, up: 1'b1};

        case (i_word.opcode)
            shi_pkg::OP_PRESTART: begin
                if (i_word.boot_epoch != 64'd0 && r_state != ST_RUNNING) begin
                    n_state   = ST_PRESTART;
                    n_locked  = 1'b0;
                    n_epoch   = i_word.boot_epoch;
                    n_reason  = shi_pkg::RSN_NONE;
                    o_cmd     = '{touch: 1'b1, idx: shi_pkg::LK_ROS, up: 1'b1};
                    ok        = 1'b1;
                end
            end
            shi_pkg::OP_CHOOSE: begin
                if (may_sel && i_word.task_code != 4'd0) begin
                    n_task = i_word.task_code;
                    ok     = 1'b1;
                end
            end
            shi_pkg::OP_CONFIRM: begin
                if (may_sel && r_task != 4'd0) begin
                    // selection id skips zero on wrap
                    n_sel    = (sel_inc == '0) ? SEL_BITS'(1) : sel_inc;
                    n_state  = ST_PENDING;
                    n_locked = 1'b1;
                    n_reason = shi_pkg::RSN_NONE;
                    o_cmd    = '{touch: 1'b1, idx: shi_pkg::LK_ROS, up: 1'b1};
                    ok       = 1'b1;
                end
            end
            shi_pkg::OP_ACK: begin
                if (ack_hit) begin
                    if (!i_word.ack_accepted) begin
                        n_state  = ST_FAULT;
                        n_locked = 1'b1;
                        n_reason = (i_word.ack_reason == shi_pkg::RSN_NONE)
                                 ? shi_pkg::RSN_REJECTED : i_word.ack_reason;
                        ok       = 1'b1;
                    end else if (i_word.ack_state == ST_SELECTED
                              || i_word.ack_state == ST_ARMED) begin
                        n_state  = t_state'(i_word.ack_state);
                        n_locked = (i_word.ack_state != ST_SELECTED);
                        if (i_word.ack_reason != shi_pkg::RSN_NONE) begin
                            n_reason = i_word.ack_reason;
                        end
                        ok       = 1'b1;
                    end
                end
            end
            shi_pkg::OP_CAR_START: begin
                if (i_word.boot_epoch != r_epoch) begin
                    n_state  = ST_FAULT;
                    n_locked = 1'b1;
                    n_reason = shi_pkg::RSN_EPO_MISM;
                end else if (r_state != ST_ARMED) begin
                    n_state  = ST_FAULT;
                    n_locked = 1'b1;
                    n_reason = shi_pkg::RSN_NO_SEL;
                end else begin
                    n_state   = ST_RUNNING;
                    n_locked  = 1'b1;
                    n_started = 1'b1;
                    o_cmd     = '{touch: 1'b1, idx: shi_pkg::LK_CAR, up: 1'b1};
                    ok        = 1'b1;
                end
            end
            shi_pkg::OP_STATUS: begin
                n_stage = i_word.stage_in;
                o_cmd   = '{touch: 1'b1, idx: shi_pkg::LK_ROS, up: 1'b1};
                ok      = 1'b1;
            end
            shi_pkg::OP_AP_LINK: begin
                o_cmd = '{touch: 1'b1, idx: shi_pkg::LK_AP, up: i_word.link_up};
                ok    = 1'b1;
            end
            shi_pkg::OP_VIS_LINK: begin
                o_cmd = '{touch: 1'b1, idx: shi_pkg::LK_VISION, up: 1'b1};
                ok    = 1'b1;
            end
            shi_pkg::OP_AUTH_LOST, shi_pkg::OP_TICK: begin
                ok = 1'b1;
                // a tick only drops authority on a stale ros link
                if (i_word.opcode == shi_pkg::OP_AUTH_LOST
                    || (!i_ros_ok && r_state != ST_LOCKED
                        && r_state != ST_RUNNING)) begin
                    n_locked = 1'b1;
                    if (r_state == ST_RUNNING) begin
                        n_state  = ST_FAULT;
                        n_reason = shi_pkg::RSN_AUTH_RUN;
                    end else begin
                        n_state  = ST_LOCKED;
                        n_reason = shi_pkg::RSN_WAIT_EPO;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    logic [CMP_W-1:0] n_sel_ext;
    assign n_sel_ext = CMP_W'(n_sel);

    always_comb begin
        o_res.op_ok            = ok;
        o_res.ilk_state        = n_state;
        o_res.ctl_lock         = n_locked;
        o_res.task_sel         = n_task;
        o_res.selection_number = n_sel_ext[31:0];
        o_res.reason_code      = n_reason;
        o_res.started          = n_started;
        o_res.stage_rpt        = n_stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOCKED;
            r_locked  <= 1'b1;
            r_task    <= '0;
            r_sel     <= '0;
            r_epoch   <= '0;
            r_reason  <= shi_pkg::RSN_WAIT_EPO;
            r_started <= 1'b0;
            r_stage   <= '0;
        end else if (i_adv) begin
            r_state   <= n_state;
            r_locked  <= n_locked;
            r_task    <= n_task;
            r_sel     <= n_sel;
            r_epoch   <= n_epoch;
            r_reason  <= n_reason;
            r_started <= n_started;
            r_stage   <= n_stage;
        end
    end

endmodule

@@ hdl/selection_handshake_interlock_unit.sv @@
// ----------------------------------------------------------------------------
// selection_handshake_interlock_unit
// Operator interlock: event words in, one status word out per event.
// ----------------------------------------------------------------------------
// Takes one event word per clock while the output is not stalled and returns
// exactly one result word for it, in order. An accepted word is held in an
// input register; when the result register is empty or being read, the state
// machine and the four link records update and the result register loads.
// The sustained rate is one word per cycle while the output is ready. The
// input side keeps accepting while a result waits, until both registers are
// full. The fresh limit register may be written only while no word is in
// flight.
module selection_handshake_interlock_unit #(
    parameter int SELECTION_ID_BITS = shi_pkg::SEL_ID_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    shi_stream_if.sink   i_in_ch,
    shi_stream_if.source o_out_ch,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata
);

    logic                r_in_valid;
    shi_pkg::t_in_word   r_in;
    logic                r_out_valid;
    shi_pkg::t_out_word  r_out;
    logic [31:0]         r_fresh_limit;

    logic                adv;
    shi_pkg::t_link_cmd  link_cmd;
    shi_pkg::t_link_stat link_stat;
    shi_pkg::t_fsm_res   fsm_res;

    assign adv           = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || adv;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    shi_fsm #(
        .SEL_BITS (SELECTION_ID_BITS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_word      (r_in),
        .i_ros_ok    (link_stat.ros_ok),
        .o_cmd       (link_cmd),
        .o_res       (fsm_res)
    );

    shi_links u_links (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_opcode      (r_in.opcode),
        .i_now_ms      (r_in.now_ms),
        .i_age_link    (r_in.age_link),
        .i_fresh_limit (r_fresh_limit),
        .i_cmd         (link_cmd),
        .o_stat        (link_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh_limit <= shi_pkg::FRESH_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_fresh_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in <= i_in_ch.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.op_ok            <= fsm_res.op_ok;
            r_out.ilk_state        <= fsm_res.ilk_state;
            r_out.ctl_lock         <= fsm_res.ctl_lock;
            r_out.task_sel         <= fsm_res.task_sel;
            r_out.selection_number <= fsm_res.selection_number;
            r_out.reason_code      <= fsm_res.reason_code;
            r_out.started          <= fsm_res.started;
            r_out.stage_rpt        <= fsm_res.stage_rpt;
            r_out.fresh_flags      <= link_stat.fresh_flags;
            r_out.link_age_ms      <= link_stat.link_age;
        end
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selection handshake interlock unit.
// ----------------------------------------------------------------------------
// Event words are pushed through the input stream. The bench keeps its own
// copy of the interlock state, predicts each status word when its event is
// accepted, and checks every returned word field by field, in order.
// The run covers directed corner cases, fresh-limit extremes, random operator
// sessions under several idle/stall mixes, and a long output hold-off.
module tb;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [3:0]  OP_UNUSED_LO = 4'd10;
    localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
    localparam int          NL           = shi_pkg::NUM_LINKS;

    typedef enum logic [2:0] {
        ST_LOCKED, ST_PRESTART, ST_PENDING, ST_SELECTED, ST_ARMED, ST_RUNNING, ST_FAULT
    } t_hmi;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    shi_stream_if #(.t_word(shi_pkg::t_in_word))  in_ch ();
    shi_stream_if #(.t_word(shi_pkg::t_out_word)) out_ch ();

    selection_handshake_interlock_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // interlock copy
    t_hmi        hmi;
    logic        ctl_locked;
    logic [3:0]  cur_task;
    logic [31:0] sel_no;
    logic [63:0] cur_epoch;
    logic [7:0]  cur_reason;
    logic        car_run;
    logic [7:0]  cur_stage;
    logic        lk_conn  [NL];
    logic [31:0] lk_stamp [NL];
    logic [31:0] lk_age   [NL];
    logic        lk_fresh [NL];
    logic [31:0] fresh_lim;

    shi_pkg::t_out_word status_q [$];
    int          n_err = 0;
    int          n_sent = 0;
    int          cycle_cnt = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_len = 0;
    logic [31:0] wall_ms = 32'd0;

    // ------------------------------------------------------------------------
    // interlock prediction
    // ------------------------------------------------------------------------
    function automatic void reset_interlock();
        hmi        = ST_LOCKED;
        ctl_locked = 1'b1;
        cur_task   = 4'd0;
        sel_no     = 32'd0;
        cur_epoch  = 64'd0;
        cur_reason = shi_pkg::RSN_WAIT_EPO;
        car_run    = 1'b0;
        cur_stage  = 8'd0;
        fresh_lim  = shi_pkg::FRESH_LIMIT_RST;
        for (int k = 0; k < NL; k++) begin
            lk_conn[k]  = 1'b0;
            lk_stamp[k] = 32'd0;
            lk_age[k]   = 32'd0;
            lk_fresh[k] = 1'b0;
        end
    endfunction

    function automatic void enter_fault(input logic [7:0] code);
        hmi        = ST_FAULT;
        ctl_locked = 1'b1;
        cur_reason = code;
    endfunction

    function automatic void refresh_link(input logic [1:0] k, input logic up,
                                         input logic [31:0] now);
        lk_conn[k]  = up;
        lk_stamp[k] = now;
    endfunction

    function automatic void revoke_authority();
        if (hmi == ST_RUNNING) begin
            enter_fault(shi_pkg::RSN_AUTH_RUN);
        end else begin
            hmi        = ST_LOCKED;
            ctl_locked = 1'b1;
            cur_reason = shi_pkg::RSN_WAIT_EPO;
        end
    endfunction

    function automatic shi_pkg::t_out_word advance_interlock(input shi_pkg::t_in_word w);
        shi_pkg::t_out_word r;
        logic        ok;
        logic [31:0] a;
        ok = 1'b0;
        case (w.opcode)
            shi_pkg::OP_PRESTART: begin
                if (w.boot_epoch != 64'd0 && hmi != ST_RUNNING) begin
                    hmi        = ST_PRESTART;
                    ctl_locked = 1'b0;
                    cur_epoch  = w.boot_epoch;
                    cur_reason = shi_pkg::RSN_NONE;
                    refresh_link(shi_pkg::LK_ROS, 1'b1, w.now_ms);
                    ok = 1'b1;
                end
            end
            shi_pkg::OP_CHOOSE: begin
                if (hmi == ST_PRESTART && !ctl_locked && w.task_code != 4'd0) begin
                    cur_task = w.task_code;
                    ok = 1'b1;
                end
            end
            shi_pkg::OP_CONFIRM: begin
                if (hmi == ST_PRESTART && !ctl_locked && cur_task != 4'd0) begin
                    sel_no = sel_no + 32'd1;
                    if (sel_no == 32'd0)
                        sel_no = 32'd1;
                    hmi        = ST_PENDING;
                    ctl_locked = 1'b1;
                    cur_reason = shi_pkg::RSN_NONE;
                    refresh_link(shi_pkg::LK_ROS, 1'b1, w.now_ms);
                    ok = 1'b1;
                end
            end
            shi_pkg::OP_ACK: begin
                if (hmi == ST_PENDING && w.ack_selection == sel_no
                        && w.boot_epoch == cur_epoch) begin
                    if (!w.ack_accepted) begin
                        enter_fault(w.ack_reason == 8'd0 ? shi_pkg::RSN_REJECTED
                                                         : w.ack_reason);
                        ok = 1'b1;
                    end else if (w.ack_state == ST_SELECTED || w.ack_state == ST_ARMED) begin
                        hmi        = t_hmi'(w.ack_state);
                        ctl_locked = (w.ack_state != ST_SELECTED);
                        if (w.ack_reason != 8'd0)
                            cur_reason = w.ack_reason;
                        ok = 1'b1;
                    end
                end
            end
            shi_pkg::OP_CAR_START: begin
                if (w.boot_epoch != cur_epoch) begin
                    enter_fault(shi_pkg::RSN_EPO_MISM);
                end else if (hmi != ST_ARMED) begin
                    enter_fault(shi_pkg::RSN_NO_SEL);
                end else begin
                    hmi        = ST_RUNNING;
                    ctl_locked = 1'b1;
                    car_run    = 1'b1;
                    refresh_link(shi_pkg::LK_CAR, 1'b1, w.now_ms);
                    ok = 1'b1;
                end
            end
            shi_pkg::OP_STATUS: begin
                cur_stage = w.stage_in;
                refresh_link(shi_pkg::LK_ROS, 1'b1, w.now_ms);
                ok = 1'b1;
            end
            shi_pkg::OP_AP_LINK: begin
                refresh_link(shi_pkg::LK_AP, w.link_up, w.now_ms);
                ok = 1'b1;
            end
            shi_pkg::OP_VIS_LINK: begin
                refresh_link(shi_pkg::LK_VISION, 1'b1, w.now_ms);
                ok = 1'b1;
            end
            shi_pkg::OP_AUTH_LOST: begin
                revoke_authority();
                ok = 1'b1;
            end
            shi_pkg::OP_TICK: begin
                for (int k = 0; k < NL; k++) begin
                    a = lk_conn[k] ? w.now_ms - lk_stamp[k] : w.now_ms;
                    lk_age[k]   = a;
                    lk_fresh[k] = lk_conn[k] && (a <= fresh_lim);
                end
                if (!lk_fresh[shi_pkg::LK_ROS] && hmi != ST_LOCKED && hmi != ST_RUNNING)
                    revoke_authority();
                ok = 1'b1;
            end
            default: ;
        endcase
        r.op_ok            = ok;
        r.ilk_state        = hmi;
        r.ctl_lock         = ctl_locked;
        r.task_sel         = cur_task;
        r.selection_number = sel_no;
        r.reason_code      = cur_reason;
        r.started          = car_run;
        r.stage_rpt        = cur_stage;
        for (int k = 0; k < NL; k++)
            r.fresh_flags[k] = lk_fresh[k];
        r.link_age_ms      = lk_age[w.age_link];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // event builders
    // ------------------------------------------------------------------------
    function automatic shi_pkg::t_in_word rand_event(input logic [3:0] op);
        shi_pkg::t_in_word w;
        // mostly small steps so the ros link stays fresh; now and then a big jump
        if ($urandom_range(39) == 0)
            wall_ms = wall_ms + $urandom_range(3000, 500);
        else
            wall_ms = wall_ms + $urandom_range(60);
        w.opcode         = op;
        w.now_ms         = wall_ms;
        w.boot_epoch     = {$urandom, $urandom};
        w.task_code      = 4'($urandom_range(15));
        w.ack_selection  = $urandom;
        w.ack_accepted   = 1'($urandom_range(1));
        w.ack_state      = 3'($urandom_range(7));
        w.ack_reason     = 8'($urandom_range(255));
        w.stage_in       = 8'($urandom_range(255));
        w.link_up        = 1'($urandom_range(1));
        w.age_link       = 2'($urandom_range(3));
        return w;
    endfunction

    function automatic shi_pkg::t_in_word epoch_event(input logic [3:0] op,
                                                      input logic [63:0] ep);
        shi_pkg::t_in_word w;
        w = rand_event(op);
        w.boot_epoch = ep;
        return w;
    endfunction

    function automatic shi_pkg::t_in_word ack_event(input logic [31:0] sel,
                                                    input logic [63:0] ep,
                                                    input logic acc, input logic [2:0] st,
                                                    input logic [7:0] rsn);
        shi_pkg::t_in_word w;
        w = epoch_event(shi_pkg::OP_ACK, ep);
        w.ack_selection = sel;
        w.ack_accepted  = acc;
        w.ack_state     = st;
        w.ack_reason    = rsn;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // valid stays high after acceptance; the next call either idles or offers
    task automatic send_word(input shi_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        status_q.push_back(advance_interlock(w));
        n_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fresh_limit(input logic [31:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        fresh_lim = v;
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            hold_left = 0;
            hold_seen = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
            if (hold_left > 0)
                hold_left--;
        end
    end

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            n_err++;
            if (n_err <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_status
        shi_pkg::t_out_word want;
        shi_pkg::t_out_word got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (status_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected status word %h", got);
            end else begin
                want = status_q.pop_front();
                compare_field("op_ok", 64'(want.op_ok), 64'(got.op_ok));
                compare_field("ilk_state", 64'(want.ilk_state), 64'(got.ilk_state));
                compare_field("ctl_lock", 64'(want.ctl_lock), 64'(got.ctl_lock));
                compare_field("task_sel", 64'(want.task_sel), 64'(got.task_sel));
                compare_field("selection_number", 64'(want.selection_number),
                              64'(got.selection_number));
                compare_field("reason_code", 64'(want.reason_code), 64'(got.reason_code));
                compare_field("started", 64'(want.started), 64'(got.started));
                compare_field("stage_rpt", 64'(want.stage_rpt), 64'(got.stage_rpt));
                compare_field("fresh_flags", 64'(want.fresh_flags), 64'(got.fresh_flags));
                compare_field("link_age_ms", 64'(want.link_age_ms), 64'(got.link_age_ms));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        shi_pkg::t_in_word w;
        idle_pct  = 0;
        stall_pct = 0;
        send_word(rand_event(OP_UNUSED_LO));
        send_word(rand_event(OP_UNUSED_HI));
        send_word(epoch_event(shi_pkg::OP_PRESTART, 64'd0));   // zero epoch refused
        w = rand_event(shi_pkg::OP_CHOOSE);
        w.task_code = 4'd5;
        send_word(w);                                        // locked: refused
        w = epoch_event(shi_pkg::OP_PRESTART, '1);
        w.now_ms = 32'hFFFF_FFF0;
        send_word(w);
        w = rand_event(shi_pkg::OP_CHOOSE);
        w.task_code = 4'd0;
        send_word(w);                                        // no task
        w = rand_event(shi_pkg::OP_CHOOSE);
        w.task_code = 4'hF;
        send_word(w);
        w = rand_event(shi_pkg::OP_CONFIRM);
        w.now_ms = 32'hFFFF_FFFF;
        send_word(w);
        send_word(ack_event(32'hFFFF_FFFF, '1, 1'b1, ST_SELECTED, 8'd0));   // wrong number
        send_word(ack_event(32'd1, 64'd0, 1'b1, ST_SELECTED, 8'd0));        // wrong epoch
        send_word(ack_event(32'd1, '1, 1'b1, ST_RUNNING, 8'd9));            // bad state
        send_word(ack_event(32'd1, '1, 1'b1, ST_SELECTED, 8'd0));           // reason kept
        send_word(epoch_event(shi_pkg::OP_CAR_START, '1));     // not armed: fault
        send_word(epoch_event(shi_pkg::OP_PRESTART, 64'd1));
        send_word(rand_event(shi_pkg::OP_CONFIRM));
        send_word(ack_event(32'd2, 64'd1, 1'b1, ST_ARMED, 8'hFF));
        send_word(epoch_event(shi_pkg::OP_CAR_START, 64'd1));
        send_word(epoch_event(shi_pkg::OP_PRESTART, 64'd7));   // refused while running
        w = rand_event(shi_pkg::OP_STATUS);
        w.stage_in = 8'hFF;
        w.now_ms = 32'd0;
        send_word(w);
        w = rand_event(shi_pkg::OP_TICK);
        w.now_ms = 32'd750;
        w.age_link = shi_pkg::LK_ROS;
        send_word(w);                                        // ros age exactly at limit
        send_word(rand_event(shi_pkg::OP_AUTH_LOST));          // after start: fault
        send_word(epoch_event(shi_pkg::OP_PRESTART, 64'd3));
        send_word(rand_event(shi_pkg::OP_CONFIRM));
        send_word(ack_event(32'd3, 64'd3, 1'b0, ST_SELECTED, 8'd0));        // rejected
        w = epoch_event(shi_pkg::OP_PRESTART, 64'd4);
        w.now_ms = 32'd5000;
        send_word(w);
        w = rand_event(shi_pkg::OP_TICK);
        w.now_ms = 32'd5751;
        send_word(w);                                        // stale ros drops authority
        send_word(epoch_event(shi_pkg::OP_CAR_START, 64'd5));  // epoch mismatch
        wait_drained();
    endtask

    task automatic test_fresh_limit();
        shi_pkg::t_in_word w;
        write_fresh_limit(32'd0);
        w = epoch_event(shi_pkg::OP_PRESTART, 64'h8000_0000_0000_0000);
        w.now_ms = 32'h1234_0000;
        send_word(w);
        w = rand_event(shi_pkg::OP_TICK);
        w.now_ms = 32'h1234_0000;
        send_word(w);                                        // age zero still fresh
        w = rand_event(shi_pkg::OP_TICK);
        w.now_ms = 32'h1234_0001;
        send_word(w);
        write_fresh_limit(32'hFFFF_FFFF);
        w = rand_event(shi_pkg::OP_AP_LINK);
        w.link_up = 1'b1;
        w.now_ms = 32'h0000_0100;
        send_word(w);
        w = rand_event(shi_pkg::OP_TICK);
        w.now_ms = 32'h0000_00FF;                            // age wraps to all ones
        w.age_link = shi_pkg::LK_AP;
        send_word(w);
        wait_drained();
    endtask

    task automatic run_session();
        shi_pkg::t_in_word w;
        logic [63:0] ep;
        int          r;
        ep = ($urandom_range(15) == 0) ? 64'd0 : {$urandom, $urandom};
        send_word(epoch_event(shi_pkg::OP_PRESTART, ep));
        if ($urandom_range(3) == 0)
            send_word(rand_event(shi_pkg::OP_STATUS));
        w = rand_event(shi_pkg::OP_CHOOSE);
        if ($urandom_range(7) == 0)
            w.task_code = 4'd0;
        send_word(w);
        if ($urandom_range(9) == 0)
            send_word(rand_event(shi_pkg::OP_TICK));
        send_word(rand_event(shi_pkg::OP_CONFIRM));
        w = ack_event(sel_no, cur_epoch, $urandom_range(9) != 0,
                      $urandom_range(1) ? ST_ARMED : ST_SELECTED,
                      $urandom_range(1) ? 8'd0 : 8'($urandom_range(255)));
        r = $urandom_range(99);
        if (r < 8)
            w.ack_selection = $urandom;
        else if (r < 16)
            w.boot_epoch[$urandom_range(63)] ^= 1'b1;
        else if (r < 22)
            w.ack_state = 3'($urandom_range(7));
        send_word(w);
        if ($urandom_range(4) != 0)
            send_word(epoch_event(shi_pkg::OP_CAR_START,
                                  $urandom_range(9) == 0 ? {$urandom, $urandom} : cur_epoch));
        repeat ($urandom_range(6, 1)) begin
            r = $urandom_range(99);
            if (r < 28)
                send_word(rand_event(shi_pkg::OP_STATUS));
            else if (r < 46)
                send_word(rand_event(shi_pkg::OP_TICK));
            else if (r < 60)
                send_word(rand_event(shi_pkg::OP_AP_LINK));
            else if (r < 72)
                send_word(rand_event(shi_pkg::OP_VIS_LINK));
            else if (r < 82)
                send_word(rand_event(shi_pkg::OP_AUTH_LOST));
            else if (r < 90)
                send_word(epoch_event(shi_pkg::OP_CAR_START, cur_epoch));
            else
                send_word(rand_event(4'($urandom_range(15))));
        end
    endtask

    task automatic test_random(input int in_idle, input int out_stall, input int n_items,
                               input logic [31:0] lim, input logic [31:0] t0);
        int stop_at;
        write_fresh_limit(lim);
        idle_pct  = in_idle;
        stall_pct = out_stall;
        wall_ms   = t0;
        stop_at   = n_sent + n_items;
        while (n_sent < stop_at) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(4, 1))
                    send_word(rand_event(4'($urandom_range(15))));
            end else begin
                run_session();
            end
        end
        wait_drained();
    endtask

    // output held off long enough that both internal registers fill
    task automatic test_backpressure();
        int stop_at;
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = 250;
        hold_req++;
        stop_at = n_sent + 30;
        while (n_sent < stop_at)
            run_session();
        wait_drained();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 32'd0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        reset_interlock();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fresh_limit();
        test_random(0, 0, 140, shi_pkg::FRESH_LIMIT_RST, 32'hFFFF_F000);
        test_random(63, 0, 140, 32'd200, $urandom);
        test_random(0, 63, 140, 32'd1500, $urandom);
        test_random(11, 11, 140, 32'd750, $urandom);
        test_backpressure();

        repeat (8) @(posedge i_clk);
        n_err += status_q.size();
        if (n_err == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
